// ----- rtl/rtmc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the range table membership counter.
// No dependencies; the front end, back end, top level and testbench import this package.
package rtmc_pkg;

   localparam int FIELD_BITS         = 63;
   localparam int COUNT_BITS         = 32;
   localparam int USED_BITS          = 7;
   localparam int MAX_RANGES_DEFAULT = 64;
   localparam int VALUE_BITS_DEFAULT = 63;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic {
      CMD_INSERT,
      CMD_QUERY
   } cmd_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } back_state_type;

   typedef struct packed {
      logic                  opcode;
      logic [FIELD_BITS-1:0] range_low;
      logic [FIELD_BITS-1:0] range_high;
      logic [FIELD_BITS-1:0] query_value;
   } req_payload_type;

   typedef struct packed {
      logic                  hit;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  insert_dropped;
      logic [USED_BITS-1:0]  entries_used;
   } rsp_payload_type;

   // Classified command: operand_a is the lower bound or the probe value,
   // operand_b the upper bound of an insert.
   typedef struct packed {
      cmd_kind_type          kind;
      logic [FIELD_BITS-1:0] operand_a;
      logic [FIELD_BITS-1:0] operand_b;
   } cmd_type;

endpackage

// ----- rtl/rtmc_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// No dependencies; payload type is supplied by the instantiating module.
interface rtmc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/rtmc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the opcode into a command, and holds
// commands in a short queue. Depends on rtmc_pkg and rtmc_stream_if.
module rtmc_front
   import rtmc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   rtmc_stream_if.sink    req_chan,
   output logic           cmd_valid,
   output cmd_type        cmd,
   input  logic           cmd_pop
);

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QLW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPW-1:0] PTR_LAST = QPW'(QUEUE_DEPTH - 1);
   localparam logic [QLW-1:0] LEVEL_FULL = QLW'(QUEUE_DEPTH);

   cmd_type        queue_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLW-1:0] level_ff, level_in;
   cmd_type        cmd_new;
   logic           push;

   // Decode the opcode and keep only the operands that the command uses.
   always_comb begin
      cmd_new = '0;
      unique case (req_chan.payload.opcode)
         OP_INSERT: begin
            cmd_new.kind      = CMD_INSERT;
            cmd_new.operand_a = req_chan.payload.range_low;
            cmd_new.operand_b = req_chan.payload.range_high;
         end
         OP_QUERY: begin
            cmd_new.kind      = CMD_QUERY;
            cmd_new.operand_a = req_chan.payload.query_value;
            cmd_new.operand_b = '0;
         end
      endcase
   end

   assign req_chan.ready = (level_ff != LEVEL_FULL);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (level_ff != '0);
   assign cmd            = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, cmd_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- rtl/rtmc_back.sv -----
`timescale 1ns / 1ps
// Back end: range memory, fill level, hit counter, scan sequencer and the
// response register. Depends on rtmc_pkg and rtmc_stream_if.
module rtmc_back
   import rtmc_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   rtmc_stream_if.source rsp_chan
);

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int FW = $clog2(MAX_RANGES + 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(MAX_RANGES);

   logic [VALUE_BITS-1:0] low_mem  [MAX_RANGES];
   logic [VALUE_BITS-1:0] high_mem [MAX_RANGES];
   logic [VALUE_BITS-1:0] rd_low_ff, rd_high_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;

   back_state_type        state_ff, state_in;
   logic [AW-1:0]         scan_idx_ff, scan_idx_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0] probe_ff, probe_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  slot_free;
   logic                  entry_hit;
   logic                  scan_last;
   logic                  finish;
   logic                  finish_hit;
   logic                  finish_drop;
   logic [FW+USED_BITS-1:0] used_ext;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign entry_hit = (probe_ff >= rd_low_ff) && (probe_ff <= rd_high_ff);
   assign scan_last = ((FW'(scan_idx_ff) + 1'b1) == fill_ff);
   assign rd_addr   = scan_idx_in;
   assign used_ext  = (FW + USED_BITS)'(fill_in);

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = '0;
      fill_in      = fill_ff;
      count_in     = count_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      finish       = 1'b0;
      finish_hit   = 1'b0;
      finish_drop  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_INSERT: begin
                     finish = 1'b1;
                     if (fill_ff == FILL_MAX) begin
                        finish_drop = 1'b1;
                     end else begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     probe_in = cmd.operand_a[VALUE_BITS-1:0];
                     if (fill_ff == '0) begin
                        finish = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (entry_hit || scan_last) begin
               finish     = 1'b1;
               finish_hit = entry_hit;
               state_in   = ST_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
      endcase

      if (finish_hit && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end

      if (finish) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.hit            = finish_hit;
         rsp_data_in.hit_count      = count_in;
         rsp_data_in.insert_dropped = finish_drop;
         rsp_data_in.entries_used   = used_ext[USED_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff    <= probe_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         low_mem[fill_ff[AW-1:0]]  <= cmd.operand_a[VALUE_BITS-1:0];
         high_mem[fill_ff[AW-1:0]] <= cmd.operand_b[VALUE_BITS-1:0];
      end
      rd_low_ff  <= low_mem[rd_addr];
      rd_high_ff <= high_mem[rd_addr];
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ----- rtl/range_table_membership_count.sv -----
`timescale 1ns / 1ps
// Range table membership counter. Each request either appends an inclusive
// range [range_low, range_high] to a table of MAX_RANGES entries, or tests
// query_value against every range stored so far; each request returns one
// response with the hit bit, the saturating 32-bit hit count, the
// insert-dropped flag (table full) and the number of stored ranges. A range
// with low above high is kept but never matches. Values are reduced to their
// low VALUE_BITS bits. In the back end an insert, and a query on an empty
// table, finish directly from idle; any other query walks the range memory,
// which has one read port, one entry per cycle starting from the first
// entry; it stops early at the first matching range, or at the last stored
// entry (the fill level) when nothing matches. A two-entry
// command queue lets new requests be taken while a scan runs, and the
// response register holds a finished response until it is taken. There is
// no clearing pass after reset: unwritten entries are never read.
// Depends on rtmc_pkg, rtmc_stream_if, rtmc_front and rtmc_back.
module range_table_membership_count
   import rtmc_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   rtmc_stream_if.sink   req_chan,
   rtmc_stream_if.source rsp_chan
);

   // Command handoff between the front queue and the back end.
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // Accept requests, decode, and hold them until the back end is free.
   rtmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Store ranges, scan them for queries, advance the counters and drive
   // the response register.
   rtmc_back #(
      .MAX_RANGES (MAX_RANGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- verif/tb_range_table_membership_count.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for range_table_membership_count: directed table plus random requests.
// Depends on rtmc_pkg, rtmc_stream_if and the range_table_membership_count RTL.
module tb_range_table_membership_count;
   import rtmc_pkg::*;

   // Table capacity and value width of the instance under test (package defaults).
   localparam int MODEL_CAPACITY = MAX_RANGES_DEFAULT;
   localparam int MODEL_VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam logic [FIELD_BITS-1:0] VALUE_MASK =
      {FIELD_BITS{1'b1}} >> (FIELD_BITS - MODEL_VALUE_BITS);

   localparam logic [FIELD_BITS-1:0] VMAX  = {FIELD_BITS{1'b1}};
   localparam logic [FIELD_BITS-1:0] VMAX1 = VMAX - 1;
   localparam logic [FIELD_BITS-1:0] ALT_A = 63'h2AAA_AAAA_AAAA_AAAA;
   localparam logic [FIELD_BITS-1:0] ALT_B = 63'h5555_5555_5555_5555;

   localparam int RANDOM_REQUESTS = 1200;
   localparam int HOLDOFF_AT      = 400;   // response count that starts the long hold-off
   localparam int HOLDOFF_CYCLES  = 250;
   // Slowest request: a full miss scan of 64 entries plus queue and handshake overhead.
   localparam int DRAIN_CYCLES    = 2 * MODEL_CAPACITY + 8;
   localparam int CYCLE_LIMIT     = 400000;

   logic clock;
   logic reset;

   rtmc_stream_if #(.payload_type(req_payload_type)) req_if ();
   rtmc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   range_table_membership_count i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // ---------------------------------------------------------------------------------------------
   // Clock and reset: 12 ns period, reset asserted from the start, released once, never asserted again.
   // ---------------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------------
   // Range table predictor: own copy of the bounds, the fill level and the hit total.
   // ---------------------------------------------------------------------------------------------
   logic [FIELD_BITS-1:0] table_low  [MODEL_CAPACITY];
   logic [FIELD_BITS-1:0] table_high [MODEL_CAPACITY];
   int unsigned           table_fill = 0;
   logic [COUNT_BITS-1:0] table_hits = '0;

   rsp_payload_type expected_responses [$];

   int unsigned errors          = 0;
   int unsigned responses_taken = 0;
   int unsigned inserts_taken   = 0;
   int unsigned inserts_refused = 0;
   int unsigned queries_taken   = 0;
   int unsigned queries_hit     = 0;

   // Apply one accepted request to the predicted table and return the response it causes.
   function automatic rsp_payload_type table_apply(input req_payload_type req);
      rsp_payload_type       res;
      logic [FIELD_BITS-1:0] probe;
      bit                    found;
      res   = '0;
      found = 1'b0;
      if (req.opcode == OP_INSERT) begin
         if (table_fill < MODEL_CAPACITY) begin
            table_low[table_fill]  = req.range_low & VALUE_MASK;
            table_high[table_fill] = req.range_high & VALUE_MASK;
            table_fill++;
         end else begin
            res.insert_dropped = 1'b1;
         end
      end else begin
         probe = req.query_value & VALUE_MASK;
         // An inverted range fails at least one of the two comparisons, so it never matches.
         for (int i = 0; i < table_fill; i++) begin
            if (probe >= table_low[i] && probe <= table_high[i]) found = 1'b1;
         end
         if (found) begin
            res.hit = 1'b1;
            if (table_hits != {COUNT_BITS{1'b1}}) table_hits++;
         end
      end
      res.hit_count    = table_hits;
      res.entries_used = USED_BITS'(table_fill);
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Random request shaping.
   // ---------------------------------------------------------------------------------------------
   function automatic logic [FIELD_BITS-1:0] random_value();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return VMAX;
         default: return FIELD_BITS'({$urandom(), $urandom()});
      endcase
   endfunction

   // Most queries probe the edges or the inside of a stored range; the rest are noise.
   function automatic logic [FIELD_BITS-1:0] probe_near_table();
      int unsigned           j;
      logic [FIELD_BITS-1:0] lo;
      logic [FIELD_BITS-1:0] hi;
      logic [63:0]           span;
      if (table_fill == 0 || $urandom_range(0, 9) < 4) return random_value();
      j  = $urandom_range(0, table_fill - 1);
      lo = table_low[j];
      hi = table_high[j];
      case ($urandom_range(0, 4))
         0: return lo - 1;
         1: return lo;
         2: return hi;
         3: return hi + 1;
         default: begin
            if (lo > hi) return lo - FIELD_BITS'($urandom_range(1, 8));
            span = {1'b0, hi} - {1'b0, lo} + 64'd1;
            return lo + FIELD_BITS'({$urandom(), $urandom()} % span);
         end
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type       req;
      logic [FIELD_BITS-1:0] a;
      logic [FIELD_BITS-1:0] b;
      req.range_low   = random_value();
      req.range_high  = random_value();
      req.query_value = random_value();
      // About one in ten is an insert: the table fills around mid-run, later inserts bounce.
      if ($urandom_range(0, 9) == 0) begin
         req.opcode = OP_INSERT;
         a = random_value();
         b = random_value();
         case ($urandom_range(0, 9))
            0, 1: begin
               // inverted range: low bound above the high one
               req.range_low  = (a > b) ? a : b;
               req.range_high = (a > b) ? b : a;
            end
            2, 3, 4: begin
               req.range_low  = (a < b) ? a : b;
               req.range_high = (a < b) ? b : a;
            end
            default: begin
               // narrow range; a wrap past the top simply makes it inverted
               req.range_low  = a;
               req.range_high = a + FIELD_BITS'($urandom_range(0, 1000));
            end
         endcase
      end else begin
         req.opcode      = OP_QUERY;
         req.query_value = probe_near_table();
      end
      return req;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Directed stimulus table. A typed answer is given only where it is obvious; every other row
   // falls back to the predictor.
   // ---------------------------------------------------------------------------------------------
   typedef struct {
      req_payload_type req;
      bit              has_answer;
      rsp_payload_type answer;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty table: every query misses
      '{'{OP_QUERY,  '0,    '0,    '0},    1'b1, '{1'b0, 32'd0, 1'b0, 7'd0}},
      '{'{OP_QUERY,  VMAX,  VMAX,  VMAX},  1'b1, '{1'b0, 32'd0, 1'b0, 7'd0}},
      // single-point range at the bottom; the query field of an insert is ignored
      '{'{OP_INSERT, '0,    '0,    VMAX},  1'b1, '{1'b0, 32'd0, 1'b0, 7'd1}},
      '{'{OP_QUERY,  VMAX,  VMAX,  '0},    1'b1, '{1'b1, 32'd1, 1'b0, 7'd1}},
      '{'{OP_QUERY,  '0,    '0,    1},     1'b0, '0},
      // single-point range at the top
      '{'{OP_INSERT, VMAX,  VMAX,  '0},    1'b1, '{1'b0, 32'd1, 1'b0, 7'd2}},
      '{'{OP_QUERY,  '0,    '0,    VMAX},  1'b1, '{1'b1, 32'd2, 1'b0, 7'd2}},
      '{'{OP_QUERY,  '0,    '0,    VMAX1}, 1'b0, '0},
      // inverted range is stored but never matches
      '{'{OP_INSERT, 500,   100,   300},   1'b0, '0},
      '{'{OP_QUERY,  100,   500,   300},   1'b0, '0},
      '{'{OP_QUERY,  '0,    '0,    500},   1'b0, '0},
      '{'{OP_QUERY,  '0,    '0,    100},   1'b0, '0},
      // ordinary range, probed just outside and on both bounds
      '{'{OP_INSERT, 1000,  2000,  ALT_A}, 1'b0, '0},
      '{'{OP_QUERY,  ALT_B, ALT_A, 999},   1'b0, '0},
      '{'{OP_QUERY,  ALT_A, ALT_B, 1000},  1'b0, '0},
      '{'{OP_QUERY,  '0,    '0,    2000},  1'b0, '0},
      '{'{OP_QUERY,  '0,    '0,    2001},  1'b0, '0},
      // alternating bit patterns on every value field
      '{'{OP_INSERT, ALT_A, ALT_B, ALT_B}, 1'b0, '0},
      '{'{OP_QUERY,  ALT_A, ALT_B, ALT_B}, 1'b0, '0},
      '{'{OP_QUERY,  ALT_B, ALT_A, ALT_A - 1}, 1'b0, '0}
   };

   // ---------------------------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------------------------
   int unsigned requests_sent = 0;

   // Offer one request after a random gap, hold it until taken, then record its expectation.
   task automatic offer_request(input req_payload_type req, input bit has_answer,
                                input rsp_payload_type answer);
      int unsigned     gap;
      rsp_payload_type predicted;
      rsp_payload_type expected;
      // every fourth block of 100 requests goes back to back
      gap = ((requests_sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= req;
      do @(posedge clock); while (!req_if.ready);
      // Accepted at this edge: advance the predictor in request order.
      predicted = table_apply(req);
      expected  = has_answer ? answer : predicted;
      expected_responses.insert(expected_responses.size(), expected);
      requests_sent++;
      if (req.opcode == OP_INSERT) begin
         inserts_taken++;
         if (predicted.insert_dropped) inserts_refused++;
      end else begin
         queries_taken++;
         if (predicted.hit) queries_hit++;
      end
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      do @(posedge clock); while (reset);

      foreach (directed_rows[r])
         offer_request(directed_rows[r].req, directed_rows[r].has_answer,
                       directed_rows[r].answer);
      repeat (RANDOM_REQUESTS) offer_request(random_request(), 1'b0, '0);
      req_if.valid <= 1'b0;

      // Drain every outstanding response, then let the back end settle.
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d inserts (%0d refused on a full table), %0d queries",
               requests_sent, inserts_taken, inserts_refused, queries_taken);
      $display("with %0d hits; one long response hold-off backed the request side up.",
               queries_hit);
      if (errors == 0) begin
         $display("range_table_membership_count verification clean");
      end else begin
         $display("range_table_membership_count verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------------
   // Response side: random ready gaps, burst stretches, and one long hold-off so the command
   // queue fills and the block stalls its request input.
   // ---------------------------------------------------------------------------------------------
   initial begin
      int unsigned gap;
      bit          holdoff_done;
      holdoff_done = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = ((responses_taken / 128) % 4 == 1) ? 0 : $urandom_range(0, 3);
         if (!holdoff_done && responses_taken >= HOLDOFF_AT) begin
            gap          = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Response checker: compare each taken response with the oldest expectation.
   // ---------------------------------------------------------------------------------------------
   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         responses_taken++;
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding: hit %0d count %0d used %0d",
                   got.hit, got.hit_count, got.entries_used);
            errors++;
         end else begin
            want = expected_responses.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("hit_count", want.hit_count, got.hit_count);
            check_field("insert_dropped", want.insert_dropped, got.insert_dropped);
            check_field("entries_used", want.entries_used, got.entries_used);
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Watchdog: stop a hung run.
   // ---------------------------------------------------------------------------------------------
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d responses outstanding", cycle_count,
             expected_responses.size());
      $display("range_table_membership_count verification failed");
      $finish;
   end

endmodule

// ----- range_table_membership_count.f -----
rtl/rtmc_pkg.sv
rtl/rtmc_stream_if.sv
rtl/rtmc_front.sv
rtl/rtmc_back.sv
rtl/range_table_membership_count.sv
verif/tb_range_table_membership_count.sv
